// File: rtl/core/ssgd_pkg.sv
// ----------------------------------------------------------------------------
// ssgd_pkg
// Shared widths, opcodes and helpers for the SGD pair-update engine.
// ----------------------------------------------------------------------------
package ssgd_pkg;

    localparam int NODE_W  = 10;               // node index width (1024 nodes)
    localparam int NODE_CNT = 1 << NODE_W;
    localparam int COORD_W = 32;               // Q16.16 coordinate
    localparam int MAG_W   = 33;               // floor(sqrt(sum of squares))
    localparam int SQ_W    = 2 * MAG_W;        // sum of squares
    localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
    localparam int SH_W    = 34;               // shift magnitude
    localparam int Q_W     = 32;               // direction quotient
    localparam int MU_W    = 17;               // step size, up to 1.0
    localparam int MOVE_W  = 35;               // move magnitude
    localparam int EXT_W   = 37;               // coordinate plus move

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PAIR  = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    localparam logic       CFG_DIMS   = 1'b0;
    localparam logic       CFG_THRESH = 1'b1;
    localparam logic [1:0] DIMS_3D    = 2'd3;
    localparam logic [1:0] DIMS_RESET = 2'd2;

    // clamp a widened coordinate back into the signed Q16.16 range
    function automatic logic [COORD_W-1:0] sat_coord(input logic [EXT_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (!v[EXT_W-1] && (|v[EXT_W-2:COORD_W-1])) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v[EXT_W-1] && !(&v[EXT_W-2:COORD_W-1])) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/ssgd_ram.sv
// ----------------------------------------------------------------------------
// ssgd_ram
// Single-port coordinate store with registered read.
// ----------------------------------------------------------------------------
module ssgd_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ssgd_pkg::NODE_W-1:0]   i_addr,
    input  logic [ssgd_pkg::COORD_W-1:0]  i_wdata,
    output logic [ssgd_pkg::COORD_W-1:0]  o_rdata
);

    logic [ssgd_pkg::COORD_W-1:0] r_mem [ssgd_pkg::NODE_CNT];
    logic [ssgd_pkg::COORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ssgd_sqrt.sv
// ----------------------------------------------------------------------------
// ssgd_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ssgd_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ssgd_pkg::SQ_W-1:0]    i_rad,
    output logic                         o_done,
    output logic [ssgd_pkg::MAG_W-1:0]   o_root
);

    logic [ssgd_pkg::SQ_W-1:0]  r_rad;
    logic [ssgd_pkg::MAG_W+2:0] r_rem;
    logic [ssgd_pkg::MAG_W-1:0] r_root;
    logic [5:0]                 r_cnt;
    logic                       r_run;
    logic                       r_done;
    logic [ssgd_pkg::MAG_W+2:0] rem_sh;
    logic [ssgd_pkg::MAG_W+2:0] trial;

    assign rem_sh = {r_rem[ssgd_pkg::MAG_W:0], r_rad[ssgd_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 6'(ssgd_pkg::MAG_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad <= {r_rad[ssgd_pkg::SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ssgd_pkg::MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ssgd_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/core/ssgd_div.sv
// ----------------------------------------------------------------------------
// ssgd_div
// Restoring divider: q = (|d| << 31) / mag, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssgd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ssgd_pkg::COORD_W-1:0]  i_num,
    input  logic [ssgd_pkg::MAG_W-1:0]    i_den,
    output logic                          o_done,
    output logic [ssgd_pkg::Q_W-1:0]      o_quot
);

    logic [ssgd_pkg::MAG_W:0]     r_rem;
    logic [ssgd_pkg::Q_W-1:0]     r_lo;
    logic [ssgd_pkg::Q_W-1:0]     r_quot;
    logic [ssgd_pkg::MAG_W-1:0]   r_den;
    logic [4:0]                   r_cnt;
    logic                         r_run;
    logic                         r_done;
    logic [ssgd_pkg::MAG_W:0]     rem_sh;

    assign rem_sh = {r_rem[ssgd_pkg::MAG_W-1:0], r_lo[ssgd_pkg::Q_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'(ssgd_pkg::Q_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend is num << 31: upper part seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {3'b000, i_num[ssgd_pkg::COORD_W-1:1]};
            r_lo   <= {i_num[0], 31'd0};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_run) begin
            r_lo <= {r_lo[ssgd_pkg::Q_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem  <= rem_sh - {1'b0, r_den};
                r_quot <= {r_quot[ssgd_pkg::Q_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[ssgd_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/core/stress_sgd_pair_update.sv
// ----------------------------------------------------------------------------
// stress_sgd_pair_update
// A pair term runs the square root, then the three dividers; one transaction
// at a time. A new start is taken in the cycle the result strobe is shown.
// Reset (i_rst_n low, synchronous) clears control, max shift and config;
// position stores are undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module stress_sgd_pair_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [ssgd_pkg::NODE_W-1:0]   i_node_a,
    input  logic [ssgd_pkg::NODE_W-1:0]   i_node_b,
    input  logic signed [31:0]            i_write_x,
    input  logic signed [31:0]            i_write_y,
    input  logic signed [31:0]            i_write_z,
    input  logic [31:0]                   i_target_distance,
    input  logic [31:0]                   i_pair_weight,
    input  logic [31:0]                   i_step_size,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_valid,
    output logic signed [31:0]            o_read_x,
    output logic signed [31:0]            o_read_y,
    output logic signed [31:0]            o_read_z,
    output logic [31:0]                   o_epoch_max_shift,
    output logic                          o_converged
);

    localparam int CW = ssgd_pkg::COORD_W;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WR    = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_RDOUT = 5'd3;
    localparam logic [4:0] S_RA    = 5'd4;
    localparam logic [4:0] S_RB    = 5'd5;
    localparam logic [4:0] S_CAPB  = 5'd6;
    localparam logic [4:0] S_SQX   = 5'd7;
    localparam logic [4:0] S_SQY   = 5'd8;
    localparam logic [4:0] S_SQZ   = 5'd9;
    localparam logic [4:0] S_ROOT  = 5'd10;
    localparam logic [4:0] S_SQRT  = 5'd11;
    localparam logic [4:0] S_MU    = 5'd12;
    localparam logic [4:0] S_SHIFT = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_MOVE  = 5'd15;
    localparam logic [4:0] S_WA    = 5'd16;
    localparam logic [4:0] S_WB    = 5'd17;
    localparam logic [4:0] S_CLOSE = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    logic [4:0] r_state;

    // config
    logic [1:0]  r_dims;
    logic [31:0] r_thresh;
    logic        three;

    // latched transaction
    logic [1:0]                 r_op;
    logic [ssgd_pkg::NODE_W-1:0] r_a, r_b;
    logic [CW-1:0]              r_wx, r_wy, r_wz;
    logic [31:0]                r_d, r_w, r_eta;

    // pair term datapath
    logic [CW-1:0]                 r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [ssgd_pkg::DIFF_W-1:0]   r_dx, r_dy, r_dz;
    logic [CW-1:0]                 abs_x, abs_y, abs_z, sq_op;
    logic [2*CW-1:0]               sq;
    logic [ssgd_pkg::SQ_W-1:0]     r_acc;
    logic [ssgd_pkg::MAG_W-1:0]    r_mag;
    logic [ssgd_pkg::MU_W-1:0]     r_mu;
    logic [63:0]                   mu_prod;
    logic [34:0]                   diff;
    logic [ssgd_pkg::SH_W-1:0]     r_adiff, r_shmag;
    logic                          r_shneg;
    logic [ssgd_pkg::MU_W+ssgd_pkg::SH_W-1:0] sh_prod;
    logic [ssgd_pkg::SH_W-1:0]     shmag;
    logic [31:0]                   r_max;

    logic                          sqrt_start, sqrt_done;
    logic [ssgd_pkg::MAG_W-1:0]    sqrt_root;
    logic                          div_start, div_done_x, div_done_y, div_done_z;
    logic [ssgd_pkg::Q_W-1:0]      q_x, q_y, q_z;
    logic [ssgd_pkg::SH_W+ssgd_pkg::Q_W-1:0] mv_x, mv_y, mv_z;
    logic [ssgd_pkg::MOVE_W-1:0]   r_rx, r_ry, r_rz;
    logic                          r_nx, r_ny, r_nz;

    // memory ports
    logic                          we_xy, we_z;
    logic [ssgd_pkg::NODE_W-1:0]   ram_addr;
    logic [CW-1:0]                 wd_x, wd_y, wd_z, rd_x, rd_y, rd_z;

    // output registers
    logic        r_valid;
    logic [31:0] r_read_x, r_read_y, r_read_z, r_oms;
    logic        r_conv;

    assign three = (r_dims == ssgd_pkg::DIMS_3D);
    assign busy  = (r_state != S_IDLE);

    // move of node a is -r, of node b is +r, r signed by shift and delta sign
    function automatic logic [CW-1:0] apply_move(input logic [CW-1:0] p,
                                                 input logic [ssgd_pkg::MOVE_W-1:0] m,
                                                 input logic add);
        logic [ssgd_pkg::EXT_W-1:0] pe, me, s;
        pe = {{(ssgd_pkg::EXT_W-CW){p[CW-1]}}, p};
        me = {2'b00, m};
        s  = add ? (pe + me) : (pe - me);
        return ssgd_pkg::sat_coord(s);
    endfunction

    // ---------------- config writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= ssgd_pkg::DIMS_RESET;
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssgd_pkg::CFG_DIMS:   r_dims   <= i_cfg_data[1:0];
                ssgd_pkg::CFG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- store access ----------------
    // single port per coordinate: read a, read b, later write a, write b
    always_comb begin
        we_xy    = 1'b0;
        we_z     = 1'b0;
        ram_addr = r_a;
        wd_x     = r_wx;
        wd_y     = r_wy;
        wd_z     = three ? r_wz : '0;
        unique case (r_state)
            S_WR: begin
                we_xy = 1'b1;
                we_z  = 1'b1;
            end
            S_RB: ram_addr = r_b;
            S_WA: begin
                we_xy = 1'b1;
                we_z  = three;
                wd_x  = apply_move(r_ax, r_rx, r_nx);
                wd_y  = apply_move(r_ay, r_ry, r_ny);
                wd_z  = apply_move(r_az, r_rz, r_nz);
            end
            S_WB: begin
                we_xy    = 1'b1;
                we_z     = three;
                ram_addr = r_b;
                wd_x     = apply_move(r_bx, r_rx, !r_nx);
                wd_y     = apply_move(r_by, r_ry, !r_ny);
                wd_z     = apply_move(r_bz, r_rz, !r_nz);
            end
            default: ;
        endcase
    end

    ssgd_ram u_ram_x (.i_clk(i_clk), .i_we(we_xy), .i_addr(ram_addr),
                      .i_wdata(wd_x), .o_rdata(rd_x));
    ssgd_ram u_ram_y (.i_clk(i_clk), .i_we(we_xy), .i_addr(ram_addr),
                      .i_wdata(wd_y), .o_rdata(rd_y));
    ssgd_ram u_ram_z (.i_clk(i_clk), .i_we(we_z), .i_addr(ram_addr),
                      .i_wdata(wd_z), .o_rdata(rd_z));

    // ---------------- arithmetic ----------------
    assign abs_x = r_dx[CW] ? CW'(-r_dx) : r_dx[CW-1:0];
    assign abs_y = r_dy[CW] ? CW'(-r_dy) : r_dy[CW-1:0];
    assign abs_z = r_dz[CW] ? CW'(-r_dz) : r_dz[CW-1:0];

    always_comb begin
        unique case (r_state)
            S_SQY:   sq_op = abs_y;
            S_SQZ:   sq_op = abs_z;
            default: sq_op = abs_x;
        endcase
    end
    assign sq = sq_op * sq_op;

    // eta*w is Q32.32; mu = 1.0 once it reaches one
    assign mu_prod = r_eta * r_w;
    assign diff    = {2'b00, r_mag} - {3'b000, r_d};
    assign sh_prod = r_mu * r_adiff;
    assign shmag   = sh_prod[ssgd_pkg::MU_W+ssgd_pkg::SH_W-1:ssgd_pkg::MU_W];

    assign sqrt_start = (r_state == S_ROOT);
    assign div_start  = (r_state == S_MU) && (r_mag != '0);

    ssgd_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
                      .i_rad(r_acc), .o_done(sqrt_done), .o_root(sqrt_root));

    // one divider lane per axis
    ssgd_div u_div_x (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
                      .i_num(abs_x), .i_den(r_mag), .o_done(div_done_x), .o_quot(q_x));
    ssgd_div u_div_y (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
                      .i_num(abs_y), .i_den(r_mag), .o_done(div_done_y), .o_quot(q_y));
    ssgd_div u_div_z (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
                      .i_num(abs_z), .i_den(r_mag), .o_done(div_done_z), .o_quot(q_z));

    assign mv_x = r_shmag * q_x;
    assign mv_y = r_shmag * q_y;
    assign mv_z = r_shmag * q_z;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_max   <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (i_opcode)
                            ssgd_pkg::OP_WRITE: r_state <= S_WR;
                            ssgd_pkg::OP_READ:  r_state <= S_RD;
                            ssgd_pkg::OP_PAIR:  r_state <= S_RA;
                            default:            r_state <= S_CLOSE;
                        endcase
                    end
                end
                S_WR:    begin r_state <= S_IDLE; r_valid <= 1'b1; end
                S_RD:    r_state <= S_RDOUT;
                S_RDOUT: begin r_state <= S_IDLE; r_valid <= 1'b1; end
                S_RA:    r_state <= S_RB;
                S_RB:    r_state <= S_CAPB;
                S_CAPB:  r_state <= S_SQX;
                S_SQX:   r_state <= S_SQY;
                S_SQY:   r_state <= S_SQZ;
                S_SQZ:   r_state <= S_ROOT;
                S_ROOT:  r_state <= S_SQRT;
                S_SQRT:  if (sqrt_done) r_state <= S_MU;
                S_MU:    r_state <= (r_mag == '0) ? S_DONE : S_SHIFT;
                S_SHIFT: begin
                    r_state <= S_DIV;
                    // track largest positive shift, clamped to 32 bits
                    if (!r_shneg && (shmag > {2'b00, r_max})) begin
                        r_max <= (|shmag[ssgd_pkg::SH_W-1:32]) ? 32'hFFFF_FFFF
                                                               : shmag[31:0];
                    end
                end
                S_DIV:   if (div_done_x && div_done_y && div_done_z) r_state <= S_MOVE;
                S_MOVE:  r_state <= S_WA;
                S_WA:    r_state <= S_WB;
                S_WB:    r_state <= S_DONE;
                S_CLOSE: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                    r_max   <= '0;
                end
                S_DONE:  begin r_state <= S_IDLE; r_valid <= 1'b1; end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op  <= i_opcode;
            r_a   <= i_node_a;
            r_b   <= i_node_b;
            r_wx  <= i_write_x;
            r_wy  <= i_write_y;
            r_wz  <= i_write_z;
            r_d   <= i_target_distance;
            r_w   <= i_pair_weight;
            r_eta <= i_step_size;
        end
        if (r_state == S_RB) begin
            r_ax <= rd_x;
            r_ay <= rd_y;
            r_az <= rd_z;
        end
        if (r_state == S_CAPB) begin
            r_bx <= rd_x;
            r_by <= rd_y;
            r_bz <= rd_z;
            r_dx <= {r_ax[CW-1], r_ax} - {rd_x[CW-1], rd_x};
            r_dy <= {r_ay[CW-1], r_ay} - {rd_y[CW-1], rd_y};
            r_dz <= three ? ({r_az[CW-1], r_az} - {rd_z[CW-1], rd_z}) : '0;
            r_mu <= (|mu_prod[63:32]) ? 17'h1_0000 : {1'b0, mu_prod[31:16]};
        end
        unique case (r_state)
            S_SQX:   r_acc <= {2'b00, sq};
            S_SQY,
            S_SQZ:   r_acc <= r_acc + {2'b00, sq};
            default: ;
        endcase
        if (r_state == S_SQRT && sqrt_done) begin
            r_mag <= sqrt_root;
        end
        if (r_state == S_MU) begin
            r_shneg <= diff[34];
            r_adiff <= diff[34] ? ssgd_pkg::SH_W'(-diff) : diff[ssgd_pkg::SH_W-1:0];
        end
        if (r_state == S_SHIFT) begin
            r_shmag <= shmag;
        end
        if (r_state == S_MOVE) begin
            r_rx <= mv_x[ssgd_pkg::SH_W+ssgd_pkg::Q_W-1:31];
            r_ry <= mv_y[ssgd_pkg::SH_W+ssgd_pkg::Q_W-1:31];
            r_rz <= mv_z[ssgd_pkg::SH_W+ssgd_pkg::Q_W-1:31];
            // true means node a moves by +r
            r_nx <= r_shneg ^ r_dx[CW];
            r_ny <= r_shneg ^ r_dy[CW];
            r_nz <= r_shneg ^ r_dz[CW];
        end
    end

    // ---------------- result fields ----------------
    always_ff @(posedge i_clk) begin
        r_read_x <= '0;
        r_read_y <= '0;
        r_read_z <= '0;
        r_oms    <= '0;
        r_conv   <= 1'b0;
        if (r_state == S_RDOUT) begin
            r_read_x <= rd_x;
            r_read_y <= rd_y;
            r_read_z <= rd_z;
        end
        if (r_state == S_CLOSE && r_op == ssgd_pkg::OP_CLOSE) begin
            r_oms  <= r_max;
            r_conv <= (r_max < r_thresh);
        end
    end

    assign o_valid           = r_valid;
    assign o_read_x          = r_read_x;
    assign o_read_y          = r_read_y;
    assign o_read_z          = r_read_z;
    assign o_epoch_max_shift = r_oms;
    assign o_converged       = r_conv;

endmodule

// File: tb/tb_stress_sgd_pair_update.sv
// ----------------------------------------------------------------------------
// tb_stress_sgd_pair_update
// Self-checking bench for the SGD pair-update engine. A queue of commands
// (write/read/pair/close transactions, config writes, drain points) feeds a
// clocked driver; a clocked monitor predicts each accepted transaction and
// compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_stress_sgd_pair_update;

    localparam int WDOG_LIMIT = 2000;   // idle cycles before giving up
    localparam int SETTLE     = 4;      // quiet cycles before a config write

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} t_cmd_kind;

    typedef struct {
        t_cmd_kind   kind;
        logic [1:0]  op;
        logic [9:0]  a, b;
        logic [31:0] wx, wy, wz, d, w, eta;
        logic        cidx;
        logic [31:0] cdata;
    } t_cmd;

    typedef struct {
        logic [31:0] rx, ry, rz, shift;
        logic        conv;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = ssgd_pkg::OP_WRITE;
    logic [9:0]  i_node_a = '0, i_node_b = '0;
    logic signed [31:0] i_write_x = '0, i_write_y = '0, i_write_z = '0;
    logic [31:0] i_target_distance = '0, i_pair_weight = '0, i_step_size = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = ssgd_pkg::CFG_DIMS;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic signed [31:0] o_read_x, o_read_y, o_read_z;
    logic [31:0] o_epoch_max_shift;
    logic        o_converged;

    stress_sgd_pair_update dut (.*);

    always #5 i_clk = ~i_clk;

    t_cmd    pending_cmds[$];
    t_result expected_results[$];
    bit      failed = 1'b0;

    // ------------------------------------------------------------------------
    // Shadow of the engine: position store, epoch peak and config
    // ------------------------------------------------------------------------
    longint      shadow_x[ssgd_pkg::NODE_CNT], shadow_y[ssgd_pkg::NODE_CNT];
    longint      shadow_z[ssgd_pkg::NODE_CNT];
    logic [31:0] peak_shift = '0;
    logic [1:0]  dims_reg = ssgd_pkg::DIMS_RESET;
    logic [31:0] thresh_reg = '0;

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [67:0] s);
        logic [63:0] r, c;
        r = '0;
        for (int bit_i = 33; bit_i >= 0; bit_i--) begin
            c = r | (64'd1 << bit_i);
            if (68'(c) * 68'(c) <= s) r = c;
        end
        return r;
    endfunction

    // displacement along one axis: |shift| * (|delta| / mag), signed
    function automatic longint axis_move(logic [63:0] shm, bit shneg, longint delta,
                                         logic [63:0] mg);
        logic [63:0]  dm, q;
        logic [127:0] p;
        longint       r;
        dm = (delta < 0) ? 64'(-delta) : 64'(delta);
        q  = (dm << 31) / mg;
        p  = 128'(shm) * 128'(q);
        r  = longint'(p >> 31);
        return (shneg != (delta < 0)) ? -r : r;
    endfunction

    function automatic void relax_pair(int a, int b, logic [31:0] d, logic [31:0] w,
                                       logic [31:0] eta);
        bit          three;
        longint      dx, dy, dz, diff, mvx, mvy, mvz;
        logic [67:0] sumsq;
        logic [63:0] mg, prod, mu, shm, adx, ady, adz;
        bit          shneg;
        three = (dims_reg == ssgd_pkg::DIMS_3D);
        dx = shadow_x[a] - shadow_x[b];
        dy = shadow_y[a] - shadow_y[b];
        dz = three ? shadow_z[a] - shadow_z[b] : 0;
        adx = (dx < 0) ? 64'(-dx) : 64'(dx);
        ady = (dy < 0) ? 64'(-dy) : 64'(dy);
        adz = (dz < 0) ? 64'(-dz) : 64'(dz);
        sumsq = 68'(adx) * 68'(adx) + 68'(ady) * 68'(ady) + 68'(adz) * 68'(adz);
        mg = floor_sqrt(sumsq);
        if (mg == 0) return;   // coincident nodes stay put
        prod  = 64'(eta) * 64'(w);
        mu    = (prod >= 64'h1_0000_0000) ? 64'd65536 : (prod >> 16);
        diff  = longint'(mg) - longint'({32'd0, d});
        shneg = diff < 0;
        shm   = (mu * ((diff < 0) ? 64'(-diff) : 64'(diff))) >> 17;
        if (!shneg && shm > 64'(peak_shift))
            peak_shift = (shm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : shm[31:0];
        mvx = axis_move(shm, shneg, dx, mg);
        mvy = axis_move(shm, shneg, dy, mg);
        shadow_x[a] = clamp_coord(shadow_x[a] - mvx);
        shadow_y[a] = clamp_coord(shadow_y[a] - mvy);
        shadow_x[b] = clamp_coord(shadow_x[b] + mvx);
        shadow_y[b] = clamp_coord(shadow_y[b] + mvy);
        if (three) begin
            mvz = axis_move(shm, shneg, dz, mg);
            shadow_z[a] = clamp_coord(shadow_z[a] - mvz);
            shadow_z[b] = clamp_coord(shadow_z[b] + mvz);
        end
    endfunction

    function automatic void predict_transaction(t_cmd c);
        t_result r;
        r = '{default: '0};
        case (c.op)
            ssgd_pkg::OP_WRITE: begin
                shadow_x[c.a] = longint'(signed'(c.wx));
                shadow_y[c.a] = longint'(signed'(c.wy));
                shadow_z[c.a] = (dims_reg == ssgd_pkg::DIMS_3D) ?
                                longint'(signed'(c.wz)) : 0;
            end
            ssgd_pkg::OP_READ: begin
                r.rx = shadow_x[c.a][31:0];
                r.ry = shadow_y[c.a][31:0];
                r.rz = shadow_z[c.a][31:0];
            end
            ssgd_pkg::OP_PAIR: relax_pair(c.a, c.b, c.d, c.w, c.eta);
            default: begin
                r.shift = peak_shift;
                r.conv  = peak_shift < thresh_reg;
                peak_shift = '0;
            end
        endcase
        expected_results.insert(expected_results.size(), r);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge, check results, record acceptance
    // ------------------------------------------------------------------------
    bit       accepted = 1'b0;
    t_cmd     driven_cmd;
    int       idle_cycles = 0;

    always @(posedge i_clk) begin
        t_result e;
        bit      activity;
        bit      took;
        activity = 1'b0;
        took     = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                activity = 1'b1;
                if (expected_results.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    failed = 1'b1;
                end else begin
                    e = expected_results.pop_front();
                    if (o_read_x !== e.rx) begin
                        $error("read_x exp %h got %h", e.rx, o_read_x); failed = 1'b1;
                    end
                    if (o_read_y !== e.ry) begin
                        $error("read_y exp %h got %h", e.ry, o_read_y); failed = 1'b1;
                    end
                    if (o_read_z !== e.rz) begin
                        $error("read_z exp %h got %h", e.rz, o_read_z); failed = 1'b1;
                    end
                    if (o_epoch_max_shift !== e.shift) begin
                        $error("epoch_max_shift exp %h got %h", e.shift, o_epoch_max_shift);
                        failed = 1'b1;
                    end
                    if (o_converged !== e.conv) begin
                        $error("converged exp %b got %b", e.conv, o_converged);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy) begin
                activity = 1'b1;
                took     = 1'b1;
                predict_transaction(driven_cmd);
            end
            if (i_cfg_we) begin
                activity = 1'b1;
                if (i_cfg_idx == ssgd_pkg::CFG_DIMS) dims_reg = i_cfg_data[1:0];
                else thresh_reg = i_cfg_data;
            end
            idle_cycles = activity ? 0 : idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
        accepted <= took;
    end

    // ------------------------------------------------------------------------
    // Driver: changes inputs at the falling edge
    // ------------------------------------------------------------------------
    int gap = 0;
    int settle = 0;
    bit steady_mode = 1'b0;   // stretch with back-to-back starts

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 149) == 0) steady_mode = ~steady_mode;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        logic nstart, nwe;
        t_cmd c;
        nstart = start;
        nwe    = 1'b0;
        if (accepted) begin
            nstart = 1'b0;
            gap = pick_gap();
        end
        if (i_rst_n && !nstart && pending_cmds.size() > 0) begin
            c = pending_cmds[0];
            if (c.kind == K_ITEM) begin
                if (gap > 0) begin
                    gap--;
                end else begin
                    void'(pending_cmds.pop_front());
                    driven_cmd        = c;
                    i_opcode          <= c.op;
                    i_node_a          <= c.a;
                    i_node_b          <= c.b;
                    i_write_x         <= c.wx;
                    i_write_y         <= c.wy;
                    i_write_z         <= c.wz;
                    i_target_distance <= c.d;
                    i_pair_weight     <= c.w;
                    i_step_size       <= c.eta;
                    nstart = 1'b1;
                end
            end else if (expected_results.size() == 0 && !busy) begin
                // engine idle: let it settle, then write config or resume
                if (settle < SETTLE) begin
                    settle++;
                end else begin
                    settle = 0;
                    void'(pending_cmds.pop_front());
                    if (c.kind == K_CFG) begin
                        nwe = 1'b1;
                        i_cfg_idx  <= c.cidx;
                        i_cfg_data <= c.cdata;
                    end
                end
            end else begin
                settle = 0;
            end
        end
        start    <= nstart;
        i_cfg_we <= nwe;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    bit  node_written[ssgd_pkg::NODE_CNT];
    int  written_list[$];

    function automatic t_cmd blank_item(logic [1:0] op);
        t_cmd c;
        c = '{kind: K_ITEM, op: op, a: $urandom, b: $urandom, wx: $urandom,
              wy: $urandom, wz: $urandom, d: $urandom, w: $urandom, eta: $urandom,
              cidx: ssgd_pkg::CFG_DIMS, cdata: '0};
        return c;
    endfunction

    function automatic void add_write(int a, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
        t_cmd c;
        c = blank_item(ssgd_pkg::OP_WRITE);
        c.a = a; c.wx = x; c.wy = y; c.wz = z;
        pending_cmds.insert(pending_cmds.size(), c);
        if (!node_written[a]) begin
            node_written[a] = 1'b1;
            written_list.insert(written_list.size(), a);
        end
    endfunction

    function automatic void add_op(logic [1:0] op, int a, int b, logic [31:0] d,
                                   logic [31:0] w, logic [31:0] eta);
        t_cmd c;
        c = blank_item(op);
        c.a = a; c.b = b; c.d = d; c.w = w; c.eta = eta;
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic void add_cfg(logic idx, logic [31:0] data);
        t_cmd c;
        c = blank_item(ssgd_pkg::OP_WRITE);
        c.kind = K_CFG; c.cidx = idx; c.cdata = data;
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic int any_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // mostly modest Q16.16 magnitudes, sometimes the full 32-bit range
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'h0;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    function automatic void build_stimulus();
        t_cmd c;
        int   pool[$];
        int   a;
        // directed: extremes, saturation, special cases
        add_write(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_write(1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_write(1, 32'h0, 32'h0, 32'h0);
        add_write(2, 32'h0, 32'h0, 32'h1234_5678);       // coincident with node 1
        add_write(3, 32'h0003_0000, 32'h0, 32'h0);
        add_op(ssgd_pkg::OP_READ, 0, 1, 0, 0, 0);
        add_op(ssgd_pkg::OP_READ, 1023, 0, 0, 0, 0);
        add_op(ssgd_pkg::OP_PAIR, 0, 1023, 32'h0, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);                                       // mu clamps, sat
        add_op(ssgd_pkg::OP_PAIR, 1, 2, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000);                                       // coincident
        add_op(ssgd_pkg::OP_PAIR, 3, 3, 32'h0, 32'h0001_0000, 32'h0001_0000); // same node
        add_op(ssgd_pkg::OP_PAIR, 1, 3, 32'h0001_0000, 32'h0, 32'h0001_0000); // zero weight
        add_op(ssgd_pkg::OP_PAIR, 1, 3, 32'hFFFF_FFFF, 32'h0001_0000,
               32'h0001_0000);                                       // pulled apart
        add_op(ssgd_pkg::OP_PAIR, 1, 3, 32'h0001_0000, 32'h0001_0000,
               32'h0000_8000);                                       // mu = 0.5
        add_op(ssgd_pkg::OP_READ, 3, 0, 0, 0, 0);
        add_op(ssgd_pkg::OP_CLOSE, 0, 0, 0, 0, 0);
        add_cfg(ssgd_pkg::CFG_DIMS, 32'd3);
        add_cfg(ssgd_pkg::CFG_THRESH, 32'hFFFF_FFFF);
        add_write(4, 32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000);
        add_write(5, 32'h0, 32'h0, 32'h8000_0000);
        add_op(ssgd_pkg::OP_PAIR, 4, 5, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000);
        add_op(ssgd_pkg::OP_READ, 4, 0, 0, 0, 0);
        add_op(ssgd_pkg::OP_READ, 5, 0, 0, 0, 0);
        add_op(ssgd_pkg::OP_CLOSE, 0, 0, 0, 0, 0);
        add_cfg(ssgd_pkg::CFG_DIMS, 32'd1);
        add_op(ssgd_pkg::OP_PAIR, 4, 5, 32'h0, 32'h0001_0000, 32'h0001_0000);
        add_op(ssgd_pkg::OP_CLOSE, 0, 0, 0, 0, 0);
        add_cfg(ssgd_pkg::CFG_THRESH, 32'h0);

        // random phases, each with its own config and a small working set
        for (int ph = 0; ph < 6; ph++) begin
            add_cfg(ssgd_pkg::CFG_DIMS, $urandom_range(0, 3));
            add_cfg(ssgd_pkg::CFG_THRESH, (ph == 5) ? 32'hFFFF_FFFF :
                    (ph % 2) ? $urandom : $urandom_range(0, 32'h0004_0000));
            pool.delete();
            for (int k = 0; k < 8; k++) begin
                a = $urandom_range(0, ssgd_pkg::NODE_CNT - 1);
                pool.insert(pool.size(), a);
                add_write(a, rand_coord(), rand_coord(), rand_coord());
            end
            for (int n = 0; n < 265; n++) begin
                if (ph == 2 && n == 130) begin
                    c = blank_item(ssgd_pkg::OP_WRITE);
                    c.kind = K_DRAIN;     // sender holds until all results are in
                    pending_cmds.insert(pending_cmds.size(), c);
                end
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: begin
                        a = ($urandom_range(0, 3) == 0) ?
                            $urandom_range(0, ssgd_pkg::NODE_CNT - 1) :
                            pool[$urandom_range(0, 7)];
                        add_write(a, rand_coord(), rand_coord(), rand_coord());
                    end
                    4, 5, 6: add_op(ssgd_pkg::OP_READ, any_written(), $urandom, 0, 0, 0);
                    7, 8: add_op(ssgd_pkg::OP_CLOSE, $urandom, $urandom, 0, 0, 0);
                    default: begin
                        a = ($urandom_range(0, 4) == 0) ? any_written()
                                                        : pool[$urandom_range(0, 7)];
                        add_op(ssgd_pkg::OP_PAIR, a,
                               ($urandom_range(0, 4) == 0) ? any_written()
                                                           : pool[$urandom_range(0, 7)],
                               ($urandom_range(0, 7) == 0) ? $urandom
                                                           : $urandom_range(0, 32'h0080_0000),
                               rand_scale(), rand_scale());
                    end
                endcase
            end
            add_op(ssgd_pkg::OP_CLOSE, 0, 0, 0, 0, 0);
        end
    endfunction

    initial begin
        build_stimulus();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && expected_results.size() == 0 && !start);
        repeat (100) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
